FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTP receiver statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RTPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RTPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RTPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/rtpstat_pkg.sv
// Package with shared types and constants for the RTP receiver statistics block.
`default_nettype none

package rtpstat_pkg;

    // Reset value of the report interval register.
    localparam logic [7:0] REPORT_RESET = 8'd5;

    // Largest interarrival time in ms kept for the jitter filter.
    localparam logic [23:0] IA_MAX = 24'hFF_FFFF;

    // Loss scale factor (tenths of a percent) and its saturation limit.
    localparam logic [9:0]         LOSS_SCALE = 10'd1000;
    localparam logic signed [10:0] LOSS_LIMIT = 11'sd1000;

    // Number of shared divider steps, one bit of the 32-bit dividends per step.
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic mult;
        logic step;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rtpstat_datapath.sv
// Datapath: packet state, jitter filter, loss divider and report remainder.
`default_nettype none

module rtpstat_datapath
    import rtpstat_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  cmd_t               cmd,
    input  wire                cfg_valid,
    input  wire  [7:0]         cfg_data,
    input  wire                s_seq_valid,
    input  wire  [30:0]        s_seq_number,
    input  wire  [47:0]        s_send_time_ms,
    input  wire  [47:0]        s_recv_time_ms,
    input  wire  [47:0]        s_arrival_ms,
    output logic signed [48:0] m_delay_ms,
    output logic signed [10:0] m_loss_tenths,
    output logic [31:0]        m_jitter_q8,
    output logic [30:0]        m_seq_echo,
    output logic               m_report_due
);

    // Control state, cleared by reset except the report interval (set to REPORT_RESET).
    logic [7:0]  interval_reg, interval_next;
    logic        have_last_reg, have_last_next;
    logic [30:0] last_seq_reg, last_seq_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] received_reg, received_next;
    logic [31:0] jitter_reg, jitter_next;
    logic [47:0] last_arr_reg, last_arr_next;

    // Per-packet working registers.
    logic [48:0] delay_reg;
    logic [23:0] ia_reg;
    logic        jit_en_reg;
    logic [32:0] dabs_reg;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic        sat_reg;
    logic        zero_reg;
    logic [31:0] lrem_reg;
    logic [31:0] lnum_reg;
    logic [9:0]  quot_reg;
    logic [7:0]  mrem_reg;
    logic [31:0] mnum_reg;

    // Combinational helpers.
    logic [47:0] arr_diff;
    logic [23:0] ia_sat;
    logic [32:0] loss_diff;
    logic [31:0] loss_mag;
    logic [32:0] jit_diff;
    logic [32:0] jit_abs;
    logic signed [33:0] jit_t;
    logic signed [33:0] jit_step;
    logic [41:0] product;
    logic [32:0] lrem_sh;
    logic [32:0] lrem_sub;
    logic [8:0]  mrem_sh;
    logic [8:0]  mrem_sub;
    logic signed [10:0] loss_val;

    // Interarrival time, clipped to zero when time goes backwards and saturated.
    always_comb begin
        arr_diff = s_arrival_ms - last_arr_reg;
        if (s_arrival_ms < last_arr_reg) begin
            ia_sat = '0;
        end else if (arr_diff > {24'd0, IA_MAX}) begin
            ia_sat = IA_MAX;
        end else begin
            ia_sat = arr_diff[23:0];
        end
    end

    // Loss difference magnitude and jitter distance for the prep step.
    always_comb begin
        loss_diff = {1'b0, expected_reg} - {1'b0, received_reg};
        loss_mag  = loss_diff[32] ? (~loss_diff[31:0] + 32'd1) : loss_diff[31:0];
        jit_diff  = {1'b0, ia_reg, 8'd0} - {1'b0, jitter_reg};
        jit_abs   = jit_diff[32] ? (~jit_diff + 33'd1) : jit_diff;
    end

    // Jitter step (d - j) / 16 truncated toward zero, and the loss numerator.
    always_comb begin
        jit_t    = $signed({1'b0, dabs_reg}) - $signed({2'b00, jitter_reg});
        jit_step = jit_t[33] ? ((jit_t + 34'sd15) >>> 4) : (jit_t >>> 4);
        product  = {10'd0, mag_reg} * {32'd0, LOSS_SCALE};
    end

    // One restoring step each for the loss quotient and the report remainder.
    always_comb begin
        lrem_sh  = {lrem_reg, lnum_reg[31]};
        lrem_sub = lrem_sh - {1'b0, expected_reg};
        mrem_sh  = {mrem_reg, mnum_reg[31]};
        mrem_sub = mrem_sh - {1'b0, interval_reg};
    end

    // Final loss value with zero and saturation handling.
    always_comb begin
        if (zero_reg) begin
            loss_val = '0;
        end else if (sat_reg) begin
            loss_val = neg_reg ? -LOSS_LIMIT : LOSS_LIMIT;
        end else if (neg_reg) begin
            loss_val = -$signed({1'b0, quot_reg});
        end else begin
            loss_val = $signed({1'b0, quot_reg});
        end
    end

    // Next values of the control state.
    always_comb begin
        interval_next  = interval_reg;
        have_last_next = have_last_reg;
        last_seq_next  = last_seq_reg;
        expected_next  = expected_reg;
        received_next  = received_reg;
        jitter_next    = jitter_reg;
        last_arr_next  = last_arr_reg;
        if (cfg_valid) begin
            interval_next = cfg_data;
        end
        if (cmd.accept) begin
            received_next = received_reg + 32'd1;
            if (!have_last_reg) begin
                expected_next = 32'd1;
            end else if (s_seq_valid && (s_seq_number > last_seq_reg)) begin
                expected_next = expected_reg + {1'b0, s_seq_number - last_seq_reg};
            end
            last_arr_next  = s_arrival_ms;
            have_last_next = s_seq_valid;
            last_seq_next  = s_seq_valid ? s_seq_number : '0;
        end
        if (cmd.mult && jit_en_reg) begin
            jitter_next = jitter_reg + jit_step[31:0];
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= REPORT_RESET;
            have_last_reg <= 1'b0;
            last_seq_reg  <= '0;
            expected_reg  <= '0;
            received_reg  <= '0;
            jitter_reg    <= '0;
            last_arr_reg  <= '0;
        end else begin
            interval_reg  <= interval_next;
            have_last_reg <= have_last_next;
            last_seq_reg  <= last_seq_next;
            expected_reg  <= expected_next;
            received_reg  <= received_next;
            jitter_reg    <= jitter_next;
            last_arr_reg  <= last_arr_next;
        end
    end

    // Working registers, stepped by the controller commands.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            delay_reg  <= {1'b0, s_recv_time_ms} - {1'b0, s_send_time_ms};
            ia_reg     <= ia_sat;
            jit_en_reg <= have_last_reg;
        end
        if (cmd.prep) begin
            dabs_reg <= jit_abs;
            mag_reg  <= loss_mag;
            neg_reg  <= loss_diff[32];
            sat_reg  <= (loss_mag >= expected_reg);
            zero_reg <= (expected_reg == 32'd0);
        end
        if (cmd.mult) begin
            lrem_reg <= {22'd0, product[41:32]};
            lnum_reg <= product[31:0];
            quot_reg <= '0;
            mrem_reg <= '0;
            mnum_reg <= received_reg;
        end
        if (cmd.step) begin
            lnum_reg <= {lnum_reg[30:0], 1'b0};
            mnum_reg <= {mnum_reg[30:0], 1'b0};
            if (!lrem_sub[32]) begin
                lrem_reg <= lrem_sub[31:0];
                quot_reg <= {quot_reg[8:0], 1'b1};
            end else begin
                lrem_reg <= lrem_sh[31:0];
                quot_reg <= {quot_reg[8:0], 1'b0};
            end
            mrem_reg <= mrem_sub[8] ? mrem_sh[7:0] : mrem_sub[7:0];
        end
    end

    // Output register, loaded once the result slot is free.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_delay_ms    <= $signed(delay_reg);
            m_loss_tenths <= loss_val;
            m_jitter_q8   <= jitter_reg;
            m_seq_echo    <= last_seq_reg;
            m_report_due  <= (interval_reg != 8'd0) && (mrem_reg == 8'd0);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rtpstat_ctrl.sv
// Controller: packet sequencing state machine and output beat handshake.
`default_nettype none
`include "assert_macros.svh"

module rtpstat_ctrl
    import rtpstat_pkg::*;
(
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  wire   m_ready,
    output cmd_t  cmd
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_cnt_reg, step_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic                slot_free;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    assign slot_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (step_cnt_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        step_cnt_next = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
            end
            ST_MULT: begin
                cmd.mult = 1'b1;
            end
            ST_DIV: begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + STEP_W'(1);
            end
            ST_DONE: begin
                cmd.out_load = slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Output beat valid: set on a load, cleared when the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // An accepted beat always starts the prep step.
    `RTPS_ASSERT_NXT(a_accept_prep, aclk, aresetn, s_valid && s_ready, state_reg == ST_PREP, "accept did not start prep")
    // The divider runs all its steps before the result is ready.
    `RTPS_ASSERT_NXT(a_div_done, aclk, aresetn, (state_reg == ST_DIV) && (step_cnt_reg == LAST_STEP), state_reg == ST_DONE, "divider did not finish")
    // Each division starts with a cleared step count.
    `RTPS_ASSERT_IMP(a_div_start, aclk, aresetn, (state_reg == ST_MULT), step_cnt_reg == '0, "step count not cleared")
    // A new result beat only appears after the done state.
    `RTPS_ASSERT_IMP(a_valid_src, aclk, aresetn, $rose(m_valid), $past(state_reg) == ST_DONE, "result beat without done")

endmodule

`default_nettype wire

FILE: hw/rtl/rtp_receiver_statistics.sv
// A result beat follows its accepted input beat through the prep, multiply, divide
// and done states; the 32-step shared restoring divider (loss quotient and report
// remainder) runs in the divide state. No new input beat is taken until the
// previous result is loaded into the output register, which waits for a free slot.
// Reset (aresetn low, synchronous) clears all counts, the jitter and the result
// valid, and sets the report interval to 5.
`default_nettype none

module rtp_receiver_statistics
    import rtpstat_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [7:0]         cfg_data,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_seq_valid,
    input  wire  [30:0]        s_seq_number,
    input  wire  [47:0]        s_send_time_ms,
    input  wire  [47:0]        s_recv_time_ms,
    input  wire  [47:0]        s_arrival_ms,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [48:0] m_delay_ms,
    output logic signed [10:0] m_loss_tenths,
    output logic [31:0]        m_jitter_q8,
    output logic [30:0]        m_seq_echo,
    output logic               m_report_due
);

    cmd_t cmd;

    // The interval register takes a write beat in any cycle.
    assign cfg_ready = 1'b1;

    rtpstat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rtpstat_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_seq_valid    (s_seq_valid),
        .s_seq_number   (s_seq_number),
        .s_send_time_ms (s_send_time_ms),
        .s_recv_time_ms (s_recv_time_ms),
        .s_arrival_ms   (s_arrival_ms),
        .m_delay_ms     (m_delay_ms),
        .m_loss_tenths  (m_loss_tenths),
        .m_jitter_q8    (m_jitter_q8),
        .m_seq_echo     (m_seq_echo),
        .m_report_due   (m_report_due)
    );

endmodule

`default_nettype wire
